### src/crtc_pkg.sv
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared types and constants for the CMOS RTC register file: command codes,
// register selects, status defaults, divider request/response and sequencer
// states.
// ----------------------------------------------------------------------------
package crtc_pkg;

    localparam int REG_COUNT = 128;
    localparam int RAM_AW    = $clog2(REG_COUNT);
    localparam logic [7:0] REG_LIMIT = 8'(REG_COUNT);

    localparam logic [2:0] CMD_IDX_WR   = 3'd0;
    localparam logic [2:0] CMD_IDX_RD   = 3'd1;
    localparam logic [2:0] CMD_DATA_WR  = 3'd2;
    localparam logic [2:0] CMD_DATA_RD  = 3'd3;
    localparam logic [2:0] CMD_HOST_SET = 3'd4;

    localparam logic [6:0] REG_SEC       = 7'h00;
    localparam logic [6:0] REG_ALM_SEC   = 7'h01;
    localparam logic [6:0] REG_MIN       = 7'h02;
    localparam logic [6:0] REG_ALM_MIN   = 7'h03;
    localparam logic [6:0] REG_HOUR      = 7'h04;
    localparam logic [6:0] REG_ALM_HOUR  = 7'h05;
    localparam logic [6:0] REG_DAY       = 7'h07;
    localparam logic [6:0] REG_MONTH     = 7'h08;
    localparam logic [6:0] REG_YEAR      = 7'h09;
    localparam logic [6:0] REG_STS_A     = 7'h0A;
    localparam logic [6:0] REG_STS_B     = 7'h0B;
    localparam logic [6:0] REG_STS_C     = 7'h0C;
    localparam logic [6:0] REG_STS_D     = 7'h0D;
    localparam logic [6:0] RAM_START     = 7'h0E;

    localparam logic [7:0] STS_A_RESET = 8'h26;
    localparam logic [7:0] STS_B_RESET = 8'h02;
    localparam logic [7:0] STS_D_VALUE = 8'h80;
    localparam int STS_B_DM_BIT  = 2;
    localparam int STS_B_UIE_BIT = 4;

    localparam int FMT_W = 6;
    localparam logic [FMT_W-1:0] DAY_VALUE   = 6'd29;
    localparam logic [FMT_W-1:0] MONTH_VALUE = 6'd7;
    localparam logic [FMT_W-1:0] YEAR_VALUE  = 6'd26;

    localparam int DIV_W = 32;
    localparam int MUL_W = 2 * DIV_W;
    localparam int DVR_W = 12;
    localparam int SHF_W = 6;

    localparam logic [DVR_W-1:0] SEC_PER_MIN  = 12'd60;
    localparam logic [DVR_W-1:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [DVR_W-1:0] HOUR_PER_DAY = 12'd24;
    localparam logic [DVR_W-1:0] BCD_RADIX    = 12'd10;

    localparam logic [DIV_W-1:0] RECIP_60   = 32'h8888_8889;
    localparam logic [SHF_W-1:0] SHIFT_60   = 6'd37;
    localparam logic [DIV_W-1:0] RECIP_3600 = 32'h91A2_B3C5;
    localparam logic [SHF_W-1:0] SHIFT_3600 = 6'd43;
    localparam logic [DIV_W-1:0] RECIP_24   = 32'hAAAA_AAAB;
    localparam logic [SHF_W-1:0] SHIFT_24   = 6'd36;
    localparam logic [DIV_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [SHF_W-1:0] SHIFT_10   = 6'd35;

    typedef enum logic [1:0] {
        DIV_BY_60,
        DIV_BY_3600,
        DIV_BY_24,
        DIV_BY_10
    } div_op_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        div_op_t          op;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DVR_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEM,
        ST_A_GO,
        ST_A_RUN,
        ST_B_GO,
        ST_B_RUN,
        ST_F_GO,
        ST_F_RUN,
        ST_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        TK_SEC,
        TK_MIN,
        TK_HOUR
    } time_kind_t;

endpackage

### src/crtc_ram.sv
// ----------------------------------------------------------------------------
// crtc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/crtc_div.sv
// ----------------------------------------------------------------------------
// crtc_div
// Shared constant divider built on one 32x32 multiplier. The first pass
// multiplies by the reciprocal of the divisor to get the quotient, the second
// multiplies the quotient back and subtracts to get the remainder.
// ----------------------------------------------------------------------------
module crtc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  crtc_pkg::div_req_t req,
    output crtc_pkg::div_rsp_t rsp
);
    import crtc_pkg::*;

    logic             busy_reg, busy_next;
    logic             phase_reg, phase_next;
    logic             done_reg, done_next;
    div_op_t          op_reg, op_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DVR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] recip;
    logic [SHF_W-1:0] shift_amt;
    logic [DIV_W-1:0] dvr;
    logic [DIV_W-1:0] mul_a;
    logic [DIV_W-1:0] mul_b;
    logic [MUL_W-1:0] product;
    logic [MUL_W-1:0] prod_shift;
    logic [DIV_W-1:0] rem_full;

    always_comb begin
        case (op_reg)
            DIV_BY_60: begin
                recip     = RECIP_60;
                shift_amt = SHIFT_60;
                dvr       = DIV_W'(SEC_PER_MIN);
            end
            DIV_BY_3600: begin
                recip     = RECIP_3600;
                shift_amt = SHIFT_3600;
                dvr       = DIV_W'(SEC_PER_HOUR);
            end
            DIV_BY_24: begin
                recip     = RECIP_24;
                shift_amt = SHIFT_24;
                dvr       = DIV_W'(HOUR_PER_DAY);
            end
            default: begin
                recip     = RECIP_10;
                shift_amt = SHIFT_10;
                dvr       = DIV_W'(BCD_RADIX);
            end
        endcase
    end

    assign mul_a      = phase_reg ? quo_reg : dvd_reg;
    assign mul_b      = phase_reg ? dvr : recip;
    assign product    = {{DIV_W{1'b0}}, mul_a} * {{DIV_W{1'b0}}, mul_b};
    assign prod_shift = product >> shift_amt;
    assign rem_full   = dvd_reg - product[DIV_W-1:0];

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            op_next    = req.op;
            dvd_next   = req.dividend;
        end else if (busy_reg) begin
            if (!phase_reg) begin
                quo_next   = prod_shift[DIV_W-1:0];
                phase_next = 1'b1;
            end else begin
                rem_next   = rem_full[DVR_W-1:0];
                phase_next = 1'b0;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg  <= op_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### src/cmos_rtc_register_file.sv
// ----------------------------------------------------------------------------
// cmos_rtc_register_file
// Index/data port RTC register file. Time registers are derived from the
// latched seconds count by a shared reciprocal-multiply divider, and BCD
// encoding reuses the same divider.
//
//  Channel | Dir | Ports                                             | Item
//  s_      | in  | s_command s_write_data s_ram_offset s_now_seconds | one access
//  m_      | out | m_read_data m_ok                                  | one result
//
//  Index and write commands go straight to the result; a RAM byte read adds
//  the ST_MEM state. Seconds use one divider operation in binary and two
//  in BCD, minutes and hours two in binary and three in BCD; a BCD date one.
//  Reset is synchronous; the register file needs no clearing pass.
//  s_ready is high only while no item is in work; a result waiting on
//  m_ready does not block the next item from being accepted.
// ----------------------------------------------------------------------------
module cmos_rtc_register_file (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_write_data,
    input  logic [6:0]  s_ram_offset,
    input  logic [31:0] s_now_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_ok
);
    import crtc_pkg::*;

    seq_state_t state_reg, state_next;

    logic [7:0]           index_reg;
    logic [7:0]           sts_a_reg;
    logic [7:0]           sts_b_reg;
    logic [DIV_W-1:0]     latched_reg;
    logic [REG_COUNT-1:0] vld_reg;
    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;
    logic                 m_ok_reg;
    logic [7:0]           res_data_reg;
    logic                 res_ok_reg;
    logic [FMT_W-1:0]     fmt_reg;
    time_kind_t           kind_reg;

    logic [6:0]        sel;
    logic [RAM_AW-1:0] sel_addr;
    logic              sel_in_range, sel_time, sel_date, sel_alarm, sel_zero;
    logic              sel_status, mem_read, mem_write;
    logic              host_ok, dm, accept, out_free, out_load;
    logic [FMT_W-1:0]  date_val;
    logic [7:0]        acc_data;
    logic              acc_ok;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign sel          = index_reg[6:0];
    assign sel_addr     = sel[RAM_AW-1:0];
    assign sel_in_range = {1'b0, sel} < REG_LIMIT;
    assign sel_time     = (sel == REG_SEC) || (sel == REG_MIN) || (sel == REG_HOUR);
    assign sel_date     = (sel == REG_DAY) || (sel == REG_MONTH) || (sel == REG_YEAR);
    assign sel_alarm    = (sel == REG_ALM_SEC) || (sel == REG_ALM_MIN)
                       || (sel == REG_ALM_HOUR);
    assign sel_zero     = sel_alarm || (sel == REG_STS_C) || !sel_in_range;
    assign sel_status   = (sel == REG_STS_A) || (sel == REG_STS_B) || (sel == REG_STS_D);
    assign mem_read     = !sel_time && !sel_date && !sel_zero && !sel_status;
    assign mem_write    = sel_in_range && !sel_alarm && (sel != REG_STS_A)
                       && (sel != REG_STS_B) && (sel != REG_STS_D);
    assign host_ok      = (s_ram_offset >= RAM_START) && ({1'b0, s_ram_offset} < REG_LIMIT);
    assign dm           = sts_b_reg[STS_B_DM_BIT];
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        case (sel)
            REG_DAY:   date_val = DAY_VALUE;
            REG_MONTH: date_val = MONTH_VALUE;
            REG_YEAR:  date_val = YEAR_VALUE;
            default:   date_val = '0;
        endcase
    end

    always_comb begin
        acc_data = '0;
        acc_ok   = 1'b1;
        case (s_command)
            CMD_IDX_WR: begin
            end
            CMD_IDX_RD: begin
                acc_data = index_reg;
            end
            CMD_DATA_WR: begin
                if (sel == REG_STS_B) begin
                    acc_ok = !(!sts_b_reg[STS_B_UIE_BIT] && s_write_data[STS_B_UIE_BIT]);
                end
            end
            CMD_DATA_RD: begin
                if (sel == REG_STS_A) begin
                    acc_data = sts_a_reg;
                end else if (sel == REG_STS_B) begin
                    acc_data = sts_b_reg;
                end else if (sel == REG_STS_D) begin
                    acc_data = STS_D_VALUE;
                end else if (sel_date) begin
                    acc_data = {2'b00, date_val};
                end
            end
            CMD_HOST_SET: begin
                acc_ok = host_ok;
            end
            default: begin
                acc_ok = 1'b0;
            end
        endcase
    end

    assign ram_we    = accept && (((s_command == CMD_DATA_WR) && mem_write)
                    || ((s_command == CMD_HOST_SET) && host_ok));
    assign ram_waddr = (s_command == CMD_HOST_SET) ? s_ram_offset[RAM_AW-1:0] : sel_addr;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_command == CMD_DATA_RD && sel_time) begin
                        state_next = ST_A_GO;
                    end else if (s_command == CMD_DATA_RD && sel_date && !dm) begin
                        state_next = ST_F_GO;
                    end else if (s_command == CMD_DATA_RD && mem_read) begin
                        state_next = ST_MEM;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MEM:   state_next = ST_DONE;
            ST_A_GO:  state_next = ST_A_RUN;
            ST_A_RUN: begin
                if (div_rsp.done) begin
                    if (kind_reg != TK_SEC) begin
                        state_next = ST_B_GO;
                    end else begin
                        state_next = dm ? ST_DONE : ST_F_GO;
                    end
                end
            end
            ST_B_GO:  state_next = ST_B_RUN;
            ST_B_RUN: begin
                if (div_rsp.done) begin
                    state_next = dm ? ST_DONE : ST_F_GO;
                end
            end
            ST_F_GO:  state_next = ST_F_RUN;
            ST_F_RUN: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = latched_reg;
        div_req.op       = DIV_BY_60;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_A_GO: begin
                div_req.start = 1'b1;
                div_req.op    = (kind_reg == TK_HOUR) ? DIV_BY_3600 : DIV_BY_60;
            end
            ST_B_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = div_rsp.quotient;
                div_req.op       = (kind_reg == TK_HOUR) ? DIV_BY_24 : DIV_BY_60;
            end
            ST_F_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(fmt_reg);
                div_req.op       = DIV_BY_10;
            end
            ST_DONE: out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            index_reg   <= '0;
            sts_a_reg   <= STS_A_RESET;
            sts_b_reg   <= STS_B_RESET;
            latched_reg <= '0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (accept) begin
                case (s_command)
                    CMD_IDX_WR: index_reg <= s_write_data;
                    CMD_DATA_WR: begin
                        if (sel == REG_STS_A) begin
                            sts_a_reg <= s_write_data;
                        end else if (sel == REG_STS_B) begin
                            sts_b_reg <= s_write_data;
                        end
                    end
                    CMD_DATA_RD: begin
                        if (sel == REG_SEC) begin
                            latched_reg <= s_now_seconds;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_data_reg <= acc_data;
            res_ok_reg   <= acc_ok;
            fmt_reg      <= date_val;
            if (sel == REG_SEC) begin
                kind_reg <= TK_SEC;
            end else if (sel == REG_MIN) begin
                kind_reg <= TK_MIN;
            end else begin
                kind_reg <= TK_HOUR;
            end
        end
        case (state_reg)
            ST_MEM: res_data_reg <= vld_reg[sel_addr] ? ram_rdata : 8'h00;
            ST_A_RUN, ST_B_RUN: begin
                if (div_rsp.done) begin
                    fmt_reg      <= div_rsp.remainder[FMT_W-1:0];
                    res_data_reg <= {2'b00, div_rsp.remainder[FMT_W-1:0]};
                end
            end
            ST_F_RUN: begin
                if (div_rsp.done) begin
                    res_data_reg <= {div_rsp.quotient[3:0], div_rsp.remainder[3:0]};
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            m_data_reg <= res_data_reg;
            m_ok_reg   <= res_ok_reg;
        end
    end

    crtc_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_write_data),
        .raddr (sel_addr),
        .rdata (ram_rdata)
    );

    crtc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_ok        = m_ok_reg;

endmodule

### src/crtc_checker.sv
// ----------------------------------------------------------------------------
// crtc_checker
// Port-level checks for the CMOS RTC register file, bound to the top level.
// ----------------------------------------------------------------------------
module crtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic        m_ok
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_ok))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_fail_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_read_data == 8'h00)
        else $error("failed item returned nonzero data");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind cmos_rtc_register_file crtc_checker u_checker (.*);
